>>> rtl/core/ofb_pkg.sv
// ofb_pkg: shared types and constants of the oled framebuffer rectangle-fill block
// used by ofb_seq and oled_framebuffer_rect_fill_top; no dependencies
package ofb_pkg;

    localparam int DEF_DISPLAY_ROWS    = 32;
    localparam int DEF_DISPLAY_COLUMNS = 128;
    localparam int PAGE_ROWS           = 8;

    typedef enum logic [1:0] {
        OP_FILL    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_PUBLISH = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_CLEAR,
        ST_PUB,
        ST_DONE
    } t_state;

    // controls from the sequencer to the memories and result register
    typedef struct packed {
        logic rd_pix;    // read pixel page byte at the walk address
        logic pub_mode;  // pixel read feeds the published buffer, not a fill
        logic clr;       // write zero to both stores at the walk address
        logic rd_pub;    // read the published buffer at the requested index
        logic load;      // load the result register
        logic res_pub;   // result comes from the published buffer read
    } t_ctl;

endpackage

>>> rtl/core/ofb_seq.sv
// ofb_seq: command sequencer and address walker of the framebuffer block
// clips rectangles, walks page bytes and drives memory controls; needs ofb_pkg
module ofb_seq
    import ofb_pkg::*;
#(
    parameter int DISPLAY_ROWS    = DEF_DISPLAY_ROWS,
    parameter int DISPLAY_COLUMNS = DEF_DISPLAY_COLUMNS,
    localparam int PAGES     = (DISPLAY_ROWS + PAGE_ROWS - 1) / PAGE_ROWS,
    localparam int BUF_BYTES = PAGES * DISPLAY_COLUMNS,
    localparam int AW        = $clog2(BUF_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_op                i_op,
    input  logic signed [8:0]  i_x_pos,
    input  logic signed [6:0]  i_y_pos,
    input  logic [7:0]         i_rect_width,
    input  logic [5:0]         i_rect_height,
    input  logic [8:0]         i_byte_index,
    input  logic               i_out_free,
    output t_ctl               o_ctl,
    output logic [AW-1:0]      o_addr,
    output logic [7:0]         o_mask
);

    localparam int CW  = $clog2(DISPLAY_COLUMNS + 1);
    localparam int RW  = $clog2(DISPLAY_ROWS + 1);
    localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int RCW = (RW > PW + 3) ? RW : PW + 3;
    localparam logic signed [10:0] COLS_S = 11'(DISPLAY_COLUMNS);
    localparam logic signed [8:0]  ROWS_S = 9'(DISPLAY_ROWS);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_base, n_base;
    logic [CW-1:0]    r_col, n_col;
    logic [PW-1:0]    r_pg, n_pg;
    logic [PW-1:0]    r_pg_last, n_pg_last;
    logic             r_res_pub, n_res_pub;
    logic [CW-1:0]    r_c0, r_c1;
    logic [RW-1:0]    r_r0, r_r1;
    logic             r_empty;

    logic               ld_clip;
    logic signed [10:0] x_s, x_end, c0_s, c1_s;
    logic signed [8:0]  y_s, y_end, r0_s, r1_s;
    logic               clip_empty;
    logic [PW-1:0]      pg_first;
    logic               last_col, last_lin;

    // clip bounds from the incoming command
    always_comb begin
        x_s   = 11'(i_x_pos);
        x_end = x_s + $signed({3'b000, i_rect_width});
        c0_s  = (x_s < 0) ? 11'sd0 : x_s;
        c1_s  = (x_end > COLS_S) ? COLS_S : x_end;
        y_s   = 9'(i_y_pos);
        y_end = y_s + $signed({3'b000, i_rect_height});
        r0_s  = (y_s < 0) ? 9'sd0 : y_s;
        r1_s  = (y_end > ROWS_S) ? ROWS_S : y_end;
        clip_empty = (c1_s <= c0_s) || (r1_s <= r0_s);
    end

    always_ff @(posedge i_clk) begin
        if (ld_clip) begin
            r_c0    <= c0_s[CW-1:0];
            r_c1    <= c1_s[CW-1:0];
            r_r0    <= r0_s[RW-1:0];
            r_r1    <= r1_s[RW-1:0];
            r_empty <= clip_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_base    <= '0;
            r_col     <= '0;
            r_pg      <= '0;
            r_pg_last <= '0;
            r_res_pub <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_col     <= n_col;
            r_pg      <= n_pg;
            r_pg_last <= n_pg_last;
            r_res_pub <= n_res_pub;
        end
    end

    // row mask of the current page
    always_comb begin
        logic [RCW-1:0] row;
        for (int b = 0; b < PAGE_ROWS; b++) begin
            row       = RCW'({r_pg, 3'(b)});
            o_mask[b] = (row >= RCW'(r_r0)) && (row < RCW'(r_r1));
        end
    end

    assign pg_first = PW'(r_r0 >> 3);
    assign last_col = (r_col + CW'(1)) == r_c1;
    assign last_lin = r_base == AW'(BUF_BYTES - 1);
    assign o_addr   = r_base + AW'(r_col);

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_col      = r_col;
        n_pg       = r_pg;
        n_pg_last  = r_pg_last;
        n_res_pub  = r_res_pub;
        ld_clip    = 1'b0;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        o_ctl.res_pub = r_res_pub;

        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                o_ctl.clr = 1'b1;
                n_base    = r_base + AW'(1);
                if (last_lin) begin
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_base    = '0;
                    n_col     = '0;
                    n_res_pub = 1'b0;
                    unique case (i_op)
                        OP_FILL: begin
                            ld_clip = 1'b1;
                            n_state = ST_SETUP;
                        end
                        OP_CLEAR:   n_state = ST_CLEAR;
                        OP_PUBLISH: n_state = ST_PUB;
                        OP_READ: begin
                            o_ctl.rd_pub = 1'b1;
                            n_res_pub    = {23'd0, i_byte_index} < 32'(BUF_BYTES);
                            n_state      = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: begin
                if (r_empty) begin
                    n_state = ST_DONE;
                end else begin
                    n_pg      = pg_first;
                    n_pg_last = PW'((r_r1 - RW'(1)) >> 3);
                    n_base    = AW'(pg_first * DISPLAY_COLUMNS);
                    n_col     = r_c0;
                    n_state   = ST_FILL;
                end
            end
            ST_FILL: begin
                o_ctl.rd_pix = 1'b1;
                if (last_col) begin
                    n_col = r_c0;
                    if (r_pg == r_pg_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_pg   = r_pg + PW'(1);
                        n_base = r_base + AW'(DISPLAY_COLUMNS);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            ST_PUB: begin
                o_ctl.rd_pix   = 1'b1;
                o_ctl.pub_mode = 1'b1;
                n_base         = r_base + AW'(1);
                if (last_lin) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

endmodule

>>> rtl/core/oled_framebuffer_rect_fill_top.sv
// oled_framebuffer_rect_fill_top: monochrome framebuffer with rectangle fill and page packing
// holds the pixel and published byte memories; needs ofb_pkg and ofb_seq
//
// usage: one command per slave transaction, one result per master transaction.
//   slave tdata : operation[1:0], x_pos[10:2], y_pos[17:11], rect_width[25:18],
//                 rect_height[31:26], byte_index[40:32], zero pad [47:41]
//   master tdata: read_byte[7:0]; zero for fill, clear and publish
// pixels sit in memory as page bytes (8 rows of one column, top row in bit 0),
// so fill, clear and publish walk page bytes at one per cycle; fill and publish
// read through the single read port of the pixel memory. fill covers the
// clipped columns of every page touched by the clipped rows. clear writes zero
// to each page byte; publish reads each page byte and writes the copy from the
// registered read data in the write-back stage.
// the block takes one command at a time; s_axis_tready is high only while idle,
// which starts the cycle after the result register loads.
// after reset the block sweeps every page byte of both memories to zero with
// s_axis_tready low. a stalled result is held in the output register and the
// next command is still accepted; its result waits until the register frees.
module oled_framebuffer_rect_fill_top
    import ofb_pkg::*;
#(
    parameter int DISPLAY_ROWS    = DEF_DISPLAY_ROWS,
    parameter int DISPLAY_COLUMNS = DEF_DISPLAY_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation, x_pos, y_pos, rect_width, rect_height, byte_index from bit 0 up
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte
    output logic [7:0]  m_axis_tdata
);

    localparam int PAGES     = (DISPLAY_ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int BUF_BYTES = PAGES * DISPLAY_COLUMNS;
    localparam int AW        = $clog2(BUF_BYTES);

    t_ctl          ctl;
    logic [AW-1:0] walk_addr;
    logic [7:0]    walk_mask;
    logic [AW-1:0] rd_pub_addr;

    logic [7:0]    r_pix_mem [BUF_BYTES];
    logic [7:0]    r_pub_mem [BUF_BYTES];
    logic [7:0]    r_pix_rdata, r_pub_rdata;
    logic          r_wb_fill, r_wb_pub;
    logic [AW-1:0] r_wb_addr;
    logic [7:0]    r_wb_mask;
    logic          r_out_valid;
    logic [7:0]    r_out_data;

    ofb_seq #(
        .DISPLAY_ROWS    (DISPLAY_ROWS),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_op          (t_op'(s_axis_tdata[1:0])),
        .i_x_pos       ($signed(s_axis_tdata[10:2])),
        .i_y_pos       ($signed(s_axis_tdata[17:11])),
        .i_rect_width  (s_axis_tdata[25:18]),
        .i_rect_height (s_axis_tdata[31:26]),
        .i_byte_index  (s_axis_tdata[40:32]),
        .i_out_free    (!r_out_valid || m_axis_tready),
        .o_ctl         (ctl),
        .o_addr        (walk_addr),
        .o_mask        (walk_mask)
    );

    assign rd_pub_addr = AW'(s_axis_tdata[40:32]);

    // write-back stage, the cycle after the pixel read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_fill <= 1'b0;
            r_wb_pub  <= 1'b0;
        end else begin
            r_wb_fill <= ctl.rd_pix && !ctl.pub_mode;
            r_wb_pub  <= ctl.rd_pix && ctl.pub_mode;
        end
        r_wb_addr <= walk_addr;
        r_wb_mask <= walk_mask;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.clr) begin
            r_pix_mem[walk_addr] <= '0;
        end else if (r_wb_fill) begin
            r_pix_mem[r_wb_addr] <= r_pix_rdata | r_wb_mask;
        end
        if (ctl.rd_pix) begin
            r_pix_rdata <= r_pix_mem[walk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.clr) begin
            r_pub_mem[walk_addr] <= '0;
        end else if (r_wb_pub) begin
            r_pub_mem[r_wb_addr] <= r_pix_rdata;
        end
        if (ctl.rd_pub) begin
            r_pub_rdata <= r_pub_mem[rd_pub_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (ctl.load) begin
            r_out_data <= ctl.res_pub ? r_pub_rdata : 8'h00;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/core/ofb_checker.sv
// ofb_checker: port-level assertions for oled_framebuffer_rect_fill_top
// bound to the top level below; uses only the top level's ports
module ofb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // one command at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // memory clearing sweep follows reset
    a_init_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("ready during clearing sweep");

    // a presented result always carries known data
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("result data unknown while valid");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind oled_framebuffer_rect_fill_top ofb_checker u_ofb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
